/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked at every rising edge of clk.
`define PFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold.
`define PFA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PFA_ASSERT(lbl, prop, msg)
`define PFA_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* hw/rtl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and constants of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int ADDR_W      = 26;
    localparam int CMD_W       = 3;
    localparam int OWNER_W     = 2;
    localparam int LOWEST_W    = 14;
    localparam int ENTRY_W     = 3;
    localparam int COL_W       = 6;   // column within a row, rows hold at most 64 frames
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;

    localparam logic [LOWEST_W-1:0] LOWEST_RESET = 14'd256;
    localparam logic [OWNER_W-1:0]  KERNEL_RESET = 2'd1;
    localparam logic [OWNER_W-1:0]  FREE_RESET   = 2'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_OWNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_OWNER   = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_ALLOC      = 3'd1,
        CMD_FREE       = 3'd2,
        CMD_SET_OWNER  = 3'd3,
        CMD_GET_OWNER  = 3'd4,
        CMD_MARK_RANGE = 3'd5
    } cmd_e;

    typedef enum logic [2:0] {
        ROP_ALLOC,
        ROP_FREE,
        ROP_SET,
        ROP_GET,
        ROP_MARK
    } row_op_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_RESP
    } state_e;

    // Operation applied to one row of the map
    typedef struct packed {
        row_op_e              kind;
        logic [COL_W-1:0]     lo;
        logic [COL_W-1:0]     hi;
        logic [OWNER_W-1:0]   owner;
    } row_op_t;

    // What the row operation found
    typedef struct packed {
        logic                 found;
        logic [COL_W-1:0]     col;
        logic [OWNER_W-1:0]   owner_rd;
    } row_res_t;

endpackage

/* hw/rtl/page_frame_allocator_unit.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator_unit
// First-fit frame allocator over a map of 3-bit frame entries held in rows.
// ----------------------------------------------------------------------------
// Rejected commands and a reversed range are answered without a map access; allocate
//   and mark range visit the map rows in turn, one row of up to 64 frames per cycle.
// Clear zeroes all ROWS rows (ROWS = FRAME_TOTAL / ROW_FRAMES, 256 by default).
// One command is worked at a time; the next beat is taken in the idle state that
//   follows the move of the result to the output register, and a result still
//   waiting there holds the next one back in the response state.
// After reset a clearing pass writes all ROWS rows to zero before the first beat
//   is taken; configuration writes still land.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_frame_allocator_unit #(
    parameter int FRAME_TOTAL = 16384,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_data,
    // command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata from bit 0: command[2:0], address[28:3], end_address[54:29],
    //                     owner_in[56:55], zero pad[63:57]
    input  logic [pfa_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata from bit 0: result_address[25:0], owner_out[27:26], ok[28],
    //                     zero pad[31:29]
    output logic [pfa_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // Map geometry: rows of up to 64 frames, at least two rows
    localparam int ROW_FRAMES = (FRAME_TOTAL >= 128) ? 64 : FRAME_TOTAL / 2;
    localparam int ROWS       = FRAME_TOTAL / ROW_FRAMES;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int COLS_W     = $clog2(ROW_FRAMES);
    localparam int FRAME_W    = ROW_AW + COLS_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ROW_DW     = ROW_FRAMES * pfa_pkg::ENTRY_W;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pfa_pkg::state_e                 state_reg, state_next;
    logic [ROW_AW-1:0]               row_cnt_reg, row_cnt_next;
    logic                            clear_resp_reg, clear_resp_next;

    logic [pfa_pkg::LOWEST_W-1:0]    lowest_reg;
    logic [pfa_pkg::OWNER_W-1:0]     kernel_reg;
    logic [pfa_pkg::OWNER_W-1:0]     free_reg;

    // latched command
    logic [pfa_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [FRAME_W-1:0]              first_reg, first_next;
    logic [FRAME_W-1:0]              last_reg, last_next;
    logic                            first_ok_reg, first_ok_next;
    logic                            last_ok_reg, last_ok_next;
    logic [pfa_pkg::OWNER_W-1:0]     owner_in_reg, owner_in_next;

    // pending result
    logic [pfa_pkg::ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [pfa_pkg::OWNER_W-1:0]     res_owner_reg, res_owner_next;
    logic                            res_ok_reg, res_ok_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [pfa_pkg::ADDR_W-1:0]      out_addr_reg, out_addr_next;
    logic [pfa_pkg::OWNER_W-1:0]     out_owner_reg, out_owner_next;
    logic                            out_ok_reg, out_ok_next;

    // ------------------------------------------------------------------
    // Map memory and row modifier
    // ------------------------------------------------------------------
    logic                            mem_we;
    logic [ROW_AW-1:0]               mem_waddr;
    logic [ROW_DW-1:0]               mem_wdata;
    logic                            mem_re;
    logic [ROW_AW-1:0]               mem_raddr;
    logic [ROW_DW-1:0]               mem_rdata;

    pfa_pkg::row_op_t                row_op;
    pfa_pkg::row_res_t               row_res;
    logic [ROW_DW-1:0]               row_new;

    pfa_map_ram #(
        .DEPTH (ROWS),
        .WIDTH (ROW_DW)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfa_row_update #(
        .ROW_FRAMES (ROW_FRAMES)
    ) u_row_update (
        .row_in  (mem_rdata),
        .op      (row_op),
        .row_out (row_new),
        .res     (row_res)
    );

    // ------------------------------------------------------------------
    // Input decode: frame numbers and their range checks
    // ------------------------------------------------------------------
    logic [31:0] in_first_wide;
    logic [31:0] in_last_wide;
    logic [31:0] lowest_wide;
    logic        lowest_in_map;
    logic [FRAME_W-1:0] low_frame;
    logic [FRAME_W-1:0] found_frame;
    logic [63:0] alloc_addr_wide;
    logic        in_beat;

    assign in_beat       = s_tvalid && s_tready;
    assign in_first_wide = 32'(s_tdata[28:3] >> PAGE_SHIFT);
    assign in_last_wide  = 32'(s_tdata[54:29] >> PAGE_SHIFT);
    assign lowest_wide   = 32'(lowest_reg);
    assign lowest_in_map = lowest_wide < 32'(FRAME_TOTAL);
    assign low_frame     = lowest_wide[FRAME_W-1:0];
    assign found_frame   = {row_cnt_reg, row_res.col[COLS_W-1:0]};
    assign alloc_addr_wide = 64'(found_frame) << PAGE_SHIFT;

    assign s_tready = (state_reg == pfa_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_ok_reg, out_owner_reg, out_addr_reg};

    // ------------------------------------------------------------------
    // Row operation for the row returned by the memory this cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        row_op       = '0;
        row_op.kind  = pfa_pkg::ROP_GET;
        row_op.owner = kernel_reg;
        case (cmd_reg)
            pfa_pkg::CMD_ALLOC:
            begin
                row_op.kind = pfa_pkg::ROP_ALLOC;
                // the search start applies only within its own row
                if (row_cnt_reg == low_frame[FRAME_W-1:COLS_W])
                begin
                    row_op.lo = pfa_pkg::COL_W'(low_frame[COLS_W-1:0]);
                end
            end
            pfa_pkg::CMD_FREE:
            begin
                row_op.kind  = pfa_pkg::ROP_FREE;
                row_op.lo    = pfa_pkg::COL_W'(first_reg[COLS_W-1:0]);
                row_op.owner = free_reg;
            end
            pfa_pkg::CMD_SET_OWNER:
            begin
                row_op.kind  = pfa_pkg::ROP_SET;
                row_op.lo    = pfa_pkg::COL_W'(first_reg[COLS_W-1:0]);
                row_op.owner = owner_in_reg;
            end
            pfa_pkg::CMD_GET_OWNER:
            begin
                row_op.kind = pfa_pkg::ROP_GET;
                row_op.lo   = pfa_pkg::COL_W'(first_reg[COLS_W-1:0]);
            end
            pfa_pkg::CMD_MARK_RANGE:
            begin
                row_op.kind = pfa_pkg::ROP_MARK;
                row_op.hi   = pfa_pkg::COL_W'(ROW_FRAMES - 1);
                if (row_cnt_reg == first_reg[FRAME_W-1:COLS_W])
                begin
                    row_op.lo = pfa_pkg::COL_W'(first_reg[COLS_W-1:0]);
                end
                if (row_cnt_reg == last_reg[FRAME_W-1:COLS_W])
                begin
                    row_op.hi = pfa_pkg::COL_W'(last_reg[COLS_W-1:0]);
                end
            end
            default:
            begin
                row_op.kind = pfa_pkg::ROP_GET;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        row_cnt_next    = row_cnt_reg;
        clear_resp_next = clear_resp_reg;
        cmd_next        = cmd_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        first_ok_next   = first_ok_reg;
        last_ok_next    = last_ok_reg;
        owner_in_next   = owner_in_reg;
        res_addr_next   = res_addr_reg;
        res_owner_next  = res_owner_reg;
        res_ok_next     = res_ok_reg;
        out_addr_next   = out_addr_reg;
        out_owner_next  = out_owner_reg;
        out_ok_next     = out_ok_reg;
        // drop the output beat once the sink takes it
        out_valid_next  = out_valid_reg && !m_tready;

        mem_we    = 1'b0;
        mem_waddr = row_cnt_reg;
        mem_wdata = row_new;
        mem_re    = 1'b0;
        mem_raddr = row_cnt_reg;

        case (state_reg)
            pfa_pkg::ST_CLEAR:
            begin
                // zero one row a cycle
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (row_cnt_reg == LAST_ROW)
                begin
                    row_cnt_next    = '0;
                    clear_resp_next = 1'b0;
                    res_addr_next   = '0;
                    res_owner_next  = '0;
                    res_ok_next     = 1'b1;
                    state_next      = clear_resp_reg ? pfa_pkg::ST_RESP : pfa_pkg::ST_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end

            pfa_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next      = s_tdata[2:0];
                    first_next    = in_first_wide[FRAME_W-1:0];
                    last_next     = in_last_wide[FRAME_W-1:0];
                    first_ok_next = in_first_wide < 32'(FRAME_TOTAL);
                    last_ok_next  = in_last_wide < 32'(FRAME_TOTAL);
                    owner_in_next = s_tdata[56:55];
                    if (s_tdata[2:0] == pfa_pkg::CMD_CLEAR)
                    begin
                        row_cnt_next    = '0;
                        clear_resp_next = 1'b1;
                        state_next      = pfa_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = pfa_pkg::ST_START;
                    end
                end
            end

            pfa_pkg::ST_START:
            begin
                // range checks, then fetch the first row
                res_addr_next  = '0;
                res_owner_next = '0;
                res_ok_next    = 1'b0;
                state_next     = pfa_pkg::ST_RESP;
                case (cmd_reg)
                    pfa_pkg::CMD_ALLOC:
                    begin
                        if (lowest_in_map)
                        begin
                            row_cnt_next = low_frame[FRAME_W-1:COLS_W];
                            mem_re       = 1'b1;
                            mem_raddr    = low_frame[FRAME_W-1:COLS_W];
                            state_next   = pfa_pkg::ST_SCAN;
                        end
                    end
                    pfa_pkg::CMD_FREE, pfa_pkg::CMD_SET_OWNER, pfa_pkg::CMD_GET_OWNER:
                    begin
                        if (first_ok_reg)
                        begin
                            row_cnt_next = first_reg[FRAME_W-1:COLS_W];
                            mem_re       = 1'b1;
                            mem_raddr    = first_reg[FRAME_W-1:COLS_W];
                            state_next   = pfa_pkg::ST_SCAN;
                        end
                    end
                    pfa_pkg::CMD_MARK_RANGE:
                    begin
                        if (first_ok_reg && last_ok_reg)
                        begin
                            if (first_reg > last_reg)
                            begin
                                // reversed range marks nothing
                                res_ok_next = 1'b1;
                            end
                            else
                            begin
                                row_cnt_next = first_reg[FRAME_W-1:COLS_W];
                                mem_re       = 1'b1;
                                mem_raddr    = first_reg[FRAME_W-1:COLS_W];
                                state_next   = pfa_pkg::ST_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            pfa_pkg::ST_SCAN:
            begin
                // row row_cnt_reg is on mem_rdata; write it back if the command changes it,
                // and fetch the next row if the scan goes on
                case (cmd_reg)
                    pfa_pkg::CMD_ALLOC:
                    begin
                        if (row_res.found)
                        begin
                            mem_we        = 1'b1;
                            res_addr_next = alloc_addr_wide[pfa_pkg::ADDR_W-1:0];
                            res_ok_next   = 1'b1;
                            state_next    = pfa_pkg::ST_RESP;
                        end
                        else if (row_cnt_reg == LAST_ROW)
                        begin
                            state_next = pfa_pkg::ST_RESP;
                        end
                        else
                        begin
                            row_cnt_next = row_cnt_reg + 1'b1;
                            mem_re       = 1'b1;
                            mem_raddr    = row_cnt_reg + 1'b1;
                        end
                    end
                    pfa_pkg::CMD_MARK_RANGE:
                    begin
                        mem_we = 1'b1;
                        if (row_cnt_reg == last_reg[FRAME_W-1:COLS_W])
                        begin
                            res_ok_next = 1'b1;
                            state_next  = pfa_pkg::ST_RESP;
                        end
                        else
                        begin
                            row_cnt_next = row_cnt_reg + 1'b1;
                            mem_re       = 1'b1;
                            mem_raddr    = row_cnt_reg + 1'b1;
                        end
                    end
                    pfa_pkg::CMD_GET_OWNER:
                    begin
                        res_owner_next = row_res.owner_rd;
                        res_ok_next    = 1'b1;
                        state_next     = pfa_pkg::ST_RESP;
                    end
                    default:
                    begin
                        // free and set owner: single entry write-back
                        mem_we      = 1'b1;
                        res_ok_next = 1'b1;
                        state_next  = pfa_pkg::ST_RESP;
                    end
                endcase
            end

            pfa_pkg::ST_RESP:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_owner_next = res_owner_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = pfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfa_pkg::ST_CLEAR;
            row_cnt_reg    <= '0;
            clear_resp_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_cnt_reg    <= row_cnt_next;
            clear_resp_reg <= clear_resp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg <= pfa_pkg::LOWEST_RESET;
            kernel_reg <= pfa_pkg::KERNEL_RESET;
            free_reg   <= pfa_pkg::FREE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfa_pkg::CFG_LOWEST_FRAME: lowest_reg <= cfg_data[pfa_pkg::LOWEST_W-1:0];
                pfa_pkg::CFG_KERNEL_OWNER: kernel_reg <= cfg_data[pfa_pkg::OWNER_W-1:0];
                pfa_pkg::CFG_FREE_OWNER:   free_reg   <= cfg_data[pfa_pkg::OWNER_W-1:0];
                default:
                begin
                    lowest_reg <= lowest_reg;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        first_ok_reg  <= first_ok_next;
        last_ok_reg   <= last_ok_next;
        owner_in_reg  <= owner_in_next;
        res_addr_reg  <= res_addr_next;
        res_owner_reg <= res_owner_next;
        res_ok_reg    <= res_ok_next;
        out_addr_reg  <= out_addr_next;
        out_owner_reg <= out_owner_next;
        out_ok_reg    <= out_ok_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PFA_ASSERT_NEVER(a_no_write_idle,
        (state_reg == pfa_pkg::ST_IDLE) && mem_we,
        "map written while idle")
    `PFA_ASSERT_NEVER(a_rw_same_row,
        mem_re && mem_we && (mem_raddr == mem_waddr),
        "read and write hit one row")
    `PFA_ASSERT(a_beat_starts,
        in_beat |=> (state_reg == pfa_pkg::ST_START || state_reg == pfa_pkg::ST_CLEAR),
        "accepted beat not started")
    `PFA_ASSERT(a_out_from_resp,
        $rose(out_valid_reg) |-> $past(state_reg == pfa_pkg::ST_RESP),
        "result beat without response state")

endmodule

/* hw/rtl/pfa_map_ram.sv */
// ----------------------------------------------------------------------------
// pfa_map_ram
// Frame map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfa_map_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/pfa_row_update.sv */
// ----------------------------------------------------------------------------
// pfa_row_update
// Modify one row of frame entries: first-fit search, free, owner update,
// owner read and range marking.
// ----------------------------------------------------------------------------
module pfa_row_update #(
    parameter int ROW_FRAMES = 64
) (
    input  logic [ROW_FRAMES*pfa_pkg::ENTRY_W-1:0] row_in,
    input  pfa_pkg::row_op_t                       op,
    output logic [ROW_FRAMES*pfa_pkg::ENTRY_W-1:0] row_out,
    output pfa_pkg::row_res_t                      res
);

    // Entry layout: bit 0 used, bits 2:1 owner
    always_comb
    begin
        logic                       found;
        logic [pfa_pkg::COL_W-1:0]  fcol;
        found   = 1'b0;
        fcol    = '0;
        row_out = row_in;
        res     = '0;
        case (op.kind)
            pfa_pkg::ROP_ALLOC:
            begin
                // highest index first so the lowest free column wins
                for (int j = ROW_FRAMES - 1; j >= 0; j--)
                begin
                    if (pfa_pkg::COL_W'(j) >= op.lo && !row_in[j*pfa_pkg::ENTRY_W])
                    begin
                        found = 1'b1;
                        fcol  = pfa_pkg::COL_W'(j);
                    end
                end
                for (int j = 0; j < ROW_FRAMES; j++)
                begin
                    if (found && pfa_pkg::COL_W'(j) == fcol)
                    begin
                        row_out[j*pfa_pkg::ENTRY_W +: pfa_pkg::ENTRY_W] = {op.owner, 1'b1};
                    end
                end
            end
            pfa_pkg::ROP_FREE:
            begin
                for (int j = 0; j < ROW_FRAMES; j++)
                begin
                    if (pfa_pkg::COL_W'(j) == op.lo)
                    begin
                        row_out[j*pfa_pkg::ENTRY_W +: pfa_pkg::ENTRY_W] = {op.owner, 1'b0};
                    end
                end
            end
            pfa_pkg::ROP_SET:
            begin
                for (int j = 0; j < ROW_FRAMES; j++)
                begin
                    if (pfa_pkg::COL_W'(j) == op.lo)
                    begin
                        row_out[j*pfa_pkg::ENTRY_W +: pfa_pkg::ENTRY_W] =
                            {op.owner, row_in[j*pfa_pkg::ENTRY_W]};
                    end
                end
            end
            pfa_pkg::ROP_GET:
            begin
                for (int j = 0; j < ROW_FRAMES; j++)
                begin
                    if (pfa_pkg::COL_W'(j) == op.lo)
                    begin
                        res.owner_rd = row_in[j*pfa_pkg::ENTRY_W+1 +: pfa_pkg::OWNER_W];
                    end
                end
            end
            pfa_pkg::ROP_MARK:
            begin
                for (int j = 0; j < ROW_FRAMES; j++)
                begin
                    if (pfa_pkg::COL_W'(j) >= op.lo && pfa_pkg::COL_W'(j) <= op.hi)
                    begin
                        row_out[j*pfa_pkg::ENTRY_W +: pfa_pkg::ENTRY_W] = {op.owner, 1'b1};
                    end
                end
            end
            default:
            begin
                row_out = row_in;
            end
        endcase
        res.found = found;
        res.col   = fcol;
    end

endmodule
